// ----- rtl/drive_command_parser_mixer_macros.svh -----
// Assertion macros shared by the drive command parser and mixer modules.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef DRIVE_COMMAND_PARSER_MIXER_MACROS_SVH
`define DRIVE_COMMAND_PARSER_MIXER_MACROS_SVH

// Same-cycle implication
`define DCPM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define DCPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dcpm_pkg.sv -----
// Package for the drive command parser and mixer: widths, character codes,
// command word type, register indexes and the fraction weight table. No dependencies.
package dcpm_pkg;

   // Frame layout
   localparam int unsigned FIELD_CHARS        = 5;
   localparam int unsigned PAYLOAD_LEN        = 11;
   localparam int unsigned SECOND_FIELD_START = 6;
   localparam int unsigned FIRST_FIELD_END    =
      (FIELD_CHARS < SECOND_FIELD_START) ? FIELD_CHARS : SECOND_FIELD_START;
   localparam int unsigned SECOND_FIELD_END   = SECOND_FIELD_START +
      ((FIELD_CHARS < PAYLOAD_LEN - SECOND_FIELD_START) ?
       FIELD_CHARS : PAYLOAD_LEN - SECOND_FIELD_START);
   localparam int unsigned COUNT_W            = $clog2(PAYLOAD_LEN + 1);

   // Fixed point
   localparam int unsigned FULL_SCALE  = 10000;
   localparam int unsigned VALUE_W     = 15;
   localparam int unsigned ACCUM_W     = 14;
   localparam int unsigned INT_SUM_W   = 18;
   localparam int unsigned GAIN_W      = 4;
   localparam int unsigned PROD_W      = 20;
   localparam int unsigned SUM_W       = 21;
   localparam int unsigned MAG_W       = 19;
   localparam int unsigned RECIP_W     = 16;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;

   // Character codes
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_V     = 8'h76;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_POINT = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Configuration registers
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_FORWARD_GAIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REVERSE_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TURN_GAIN    = 2'd2;
   localparam logic [GAIN_W-1:0] FORWARD_GAIN_RESET = 4'd6;
   localparam logic [GAIN_W-1:0] REVERSE_GAIN_RESET = 4'd5;
   localparam logic [GAIN_W-1:0] TURN_GAIN_RESET    = 4'd4;

   // Command queue
   localparam int unsigned CMD_QUEUE_DEPTH = 2;
   localparam int unsigned CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
   localparam int unsigned CMD_COUNT_W     = $clog2(CMD_QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CASE_FORWARD = 2'd0,
      CASE_REVERSE = 2'd1,
      CASE_TURN    = 2'd2
   } drive_case_type;

   // One parsed command, passed from parser to mixer
   typedef struct packed {
      logic                       is_vertical;
      logic signed [VALUE_W-1:0]  first_value;
      logic signed [VALUE_W-1:0]  second_value;
   } cmd_type;

   // Weight of the n-th fraction digit in units of 1/10000
   function automatic logic [9:0] frac_weight(input logic [1:0] idx);
      logic [9:0] w;
      case (idx)
         2'd0:    w = 10'd1000;
         2'd1:    w = 10'd100;
         2'd2:    w = 10'd10;
         default: w = 10'd1;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/dcpm_if.sv -----
// Channel interfaces of the drive command parser and mixer: byte input,
// drive result and register write port. Depends on dcpm_pkg.
interface dcpm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dcpm_rsp_if import dcpm_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] left_drive;
   logic signed [VALUE_W-1:0] right_drive;
   logic [1:0]                drive_case;
   modport source (output valid, output left_drive, output right_drive,
                   output drive_case, input ready);
   modport sink   (input valid, input left_drive, input right_drive,
                   input drive_case, output ready);
endinterface

interface dcpm_csr_if import dcpm_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [GAIN_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/dcpm_parser.sv -----
// Front end: frames header and payload bytes and parses the two decimal
// fields into fixed point. Depends on dcpm_pkg and dcpm_if.
module dcpm_parser import dcpm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dcpm_req_if.sink  req,
   output cmd_type   cmd_data,
   output logic      cmd_push,
   input  logic      cmd_full
);

   typedef enum logic [1:0] {
      PH_LEADING,
      PH_INTEGER,
      PH_FRACTION,
      PH_STOPPED
   } phase_type;

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      vertical_ff, vertical_in;
   phase_type                 phase_ff, phase_in;
   logic                      negative_ff, negative_in;
   logic [2:0]                frac_digits_ff, frac_digits_in;
   logic [ACCUM_W-1:0]        accum_ff, accum_in;
   logic signed [VALUE_W-1:0] first_value_ff, first_value_in;

   logic                      accept, last, split, feed;
   logic [COUNT_W-1:0]        pos;
   logic [7:0]                c;
   logic                      is_digit, is_space, is_sign;
   logic [3:0]                digit;
   phase_type                 phase_b, phase_f, phase_eff;
   logic                      neg_b, neg_f;
   logic [2:0]                fd_b, fd_f;
   logic [ACCUM_W-1:0]        acc_b, acc_f;
   logic [INT_SUM_W-1:0]      int_sum;
   logic [VALUE_W-1:0]        frac_sum;
   logic signed [VALUE_W-1:0] value_now, value_fed;

   // Classify the byte and the payload position
   assign c        = req.rx_byte;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   assign is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
   assign digit    = 4'(c - CHAR_ZERO);
   assign pos      = count_ff - COUNT_W'(1);
   assign last     = (count_ff == COUNT_W'(PAYLOAD_LEN));
   assign split    = (pos == COUNT_W'(SECOND_FIELD_START));
   assign feed     = (pos < COUNT_W'(FIRST_FIELD_END)) ||
                     ((pos >= COUNT_W'(SECOND_FIELD_START)) &&
                      (pos < COUNT_W'(SECOND_FIELD_END)));

   // Stall only when a finished command cannot enter the queue
   assign req.ready = !(last && cmd_full);
   assign accept    = req.valid && req.ready;

   // Start the second field from a clean state
   assign phase_b = split ? PH_LEADING : phase_ff;
   assign neg_b   = split ? 1'b0 : negative_ff;
   assign fd_b    = split ? 3'd0 : frac_digits_ff;
   assign acc_b   = split ? '0 : accum_ff;

   assign int_sum  = ({{(INT_SUM_W-ACCUM_W){1'b0}}, acc_b} << 3) +
                     ({{(INT_SUM_W-ACCUM_W){1'b0}}, acc_b} << 1) +
                     ({{(INT_SUM_W-4){1'b0}}, digit} * INT_SUM_W'(FULL_SCALE));
   assign frac_sum = {{(VALUE_W-ACCUM_W){1'b0}}, acc_b} +
                     ({{(VALUE_W-4){1'b0}}, digit} *
                      {{(VALUE_W-10){1'b0}}, frac_weight(fd_b[1:0])});

   // Feed one byte through the field scanner
   always_comb begin
      phase_f   = phase_b;
      neg_f     = neg_b;
      fd_f      = fd_b;
      acc_f     = acc_b;
      phase_eff = phase_b;
      if (feed) begin
         if (phase_b == PH_LEADING) begin
            if (is_space) begin
               phase_eff = PH_LEADING;
            end else if (is_sign) begin
               neg_f     = (c == CHAR_MINUS);
               phase_f   = PH_INTEGER;
               phase_eff = PH_LEADING;
            end else begin
               phase_f   = PH_INTEGER;
               phase_eff = PH_INTEGER;
            end
         end
         case (phase_eff)
            PH_INTEGER: begin
               if (is_digit) begin
                  acc_f = (int_sum > INT_SUM_W'(FULL_SCALE)) ?
                          ACCUM_W'(FULL_SCALE) : int_sum[ACCUM_W-1:0];
               end else if (c == CHAR_POINT) begin
                  phase_f = PH_FRACTION;
               end else begin
                  phase_f = PH_STOPPED;
               end
            end
            PH_FRACTION: begin
               if (is_digit) begin
                  if (fd_b < 3'd4) begin
                     acc_f = (frac_sum > VALUE_W'(FULL_SCALE)) ?
                             ACCUM_W'(FULL_SCALE) : frac_sum[ACCUM_W-1:0];
                     fd_f  = fd_b + 3'd1;
                  end
               end else begin
                  phase_f = PH_STOPPED;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign value_now = negative_ff ? -$signed({1'b0, accum_ff}) : $signed({1'b0, accum_ff});
   assign value_fed = neg_f ? -$signed({1'b0, acc_f}) : $signed({1'b0, acc_f});

   // Advance the frame counter and field state
   always_comb begin
      count_in       = count_ff;
      vertical_in    = vertical_ff;
      phase_in       = phase_ff;
      negative_in    = negative_ff;
      frac_digits_in = frac_digits_ff;
      accum_in       = accum_ff;
      first_value_in = first_value_ff;
      if (accept) begin
         if (count_ff == '0) begin
            if ((c == CHAR_H) || (c == CHAR_V)) begin
               vertical_in    = (c == CHAR_V);
               count_in       = COUNT_W'(1);
               phase_in       = PH_LEADING;
               negative_in    = 1'b0;
               frac_digits_in = 3'd0;
               accum_in       = '0;
            end
         end else begin
            if (split) begin
               first_value_in = value_now;
            end
            if (last) begin
               count_in       = '0;
               phase_in       = PH_LEADING;
               negative_in    = 1'b0;
               frac_digits_in = 3'd0;
               accum_in       = '0;
            end else begin
               count_in       = count_ff + COUNT_W'(1);
               phase_in       = phase_f;
               negative_in    = neg_f;
               frac_digits_in = fd_f;
               accum_in       = acc_f;
            end
         end
      end
   end

   // Hand the finished command to the queue
   assign cmd_push              = accept && last;
   assign cmd_data.is_vertical  = vertical_ff;
   assign cmd_data.first_value  = first_value_ff;
   assign cmd_data.second_value = value_fed;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         vertical_ff    <= 1'b0;
         phase_ff       <= PH_LEADING;
         negative_ff    <= 1'b0;
         frac_digits_ff <= 3'd0;
         accum_ff       <= '0;
         first_value_ff <= '0;
      end else begin
         count_ff       <= count_in;
         vertical_ff    <= vertical_in;
         phase_ff       <= phase_in;
         negative_ff    <= negative_in;
         frac_digits_ff <= frac_digits_in;
         accum_ff       <= accum_in;
         first_value_ff <= first_value_in;
      end
   end

endmodule

// ----- rtl/dcpm_cmd_fifo.sv -----
// Short command queue between parser and mixer, held in flip-flops.
// Depends on dcpm_pkg and the assertion macro header.
`include "drive_command_parser_mixer_macros.svh"

module dcpm_cmd_fifo import dcpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type                entries_ff [CMD_QUEUE_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_COUNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CMD_COUNT_W'(CMD_QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   // Advance pointers with explicit wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CMD_COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CMD_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry; payload needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DCPM_ASSERT_IMPLIES(a_no_push_full, push, !full, "command pushed into full queue")
   `DCPM_ASSERT_IMPLIES(a_no_pop_empty, pop, !empty, "command popped from empty queue")
   `DCPM_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after a lone push")

endmodule

// ----- rtl/dcpm_mixer.sv -----
// Back end: holds gains and speeds, mixes left and right drive through a
// three-stage pipeline with output register. Depends on dcpm_pkg, dcpm_if, macros.
`include "drive_command_parser_mixer_macros.svh"

module dcpm_mixer import dcpm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dcpm_csr_if.sink   csr,
   dcpm_rsp_if.source rsp,
   input  cmd_type    cmd_data,
   input  logic       cmd_empty,
   output logic       cmd_pop
);

   logic [GAIN_W-1:0]         gain_fwd_ff, gain_rev_ff, gain_turn_ff;
   logic signed [VALUE_W-1:0] fwd_ff, bwd_ff, left_ff, right_ff;
   logic signed [VALUE_W-1:0] fwd_in, bwd_in, left_in, right_in;

   logic                      advance;
   drive_case_type            case_sel;
   logic signed [PROD_W-1:0]  prod_fwd, prod_bwd, base_in, turn_l_in, turn_r_in;

   logic                      s1_valid_ff;
   drive_case_type            s1_case_ff;
   logic signed [PROD_W-1:0]  base_ff, turn_l_ff, turn_r_ff;

   logic signed [SUM_W-1:0]   sum_l, sum_r;
   logic [SUM_W-1:0]          abs_l, abs_r;
   logic                      s2_valid_ff;
   drive_case_type            s2_case_ff;
   logic [MAG_W-1:0]          mag_l_ff, mag_r_ff;
   logic                      neg_l_ff, neg_r_ff;

   logic [MAG_W+RECIP_W-1:0]  recip_l, recip_r;
   logic [VALUE_W-1:0]        quot_l, quot_r, sat_l, sat_r;
   logic                      out_valid_ff;
   drive_case_type            out_case_ff;
   logic signed [VALUE_W-1:0] out_left_ff, out_right_ff;

   // Register writes; unknown indexes drop
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_fwd_ff  <= FORWARD_GAIN_RESET;
         gain_rev_ff  <= REVERSE_GAIN_RESET;
         gain_turn_ff <= TURN_GAIN_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_FORWARD_GAIN: gain_fwd_ff  <= csr.data;
            REG_REVERSE_GAIN: gain_rev_ff  <= csr.data;
            REG_TURN_GAIN:    gain_turn_ff <= csr.data;
            default: begin
            end
         endcase
      end
   end

   // Whole pipeline moves when the output register is free or being taken
   assign advance = !out_valid_ff || rsp.ready;
   assign cmd_pop = advance && !cmd_empty;

   // Update the stored speeds with the popped command
   assign fwd_in   = cmd_data.is_vertical ? cmd_data.first_value  : fwd_ff;
   assign bwd_in   = cmd_data.is_vertical ? cmd_data.second_value : bwd_ff;
   assign left_in  = cmd_data.is_vertical ? left_ff  : cmd_data.first_value;
   assign right_in = cmd_data.is_vertical ? right_ff : cmd_data.second_value;

   always_comb begin
      if (fwd_in > 0) begin
         case_sel = CASE_FORWARD;
      end else if (bwd_in > 0) begin
         case_sel = CASE_REVERSE;
      end else begin
         case_sel = CASE_TURN;
      end
   end

   // Stage one: weight speeds by gains, turn terms crossed
   assign prod_fwd  = PROD_W'(fwd_in)   * PROD_W'($signed({1'b0, gain_fwd_ff}));
   assign prod_bwd  = PROD_W'(bwd_in)   * PROD_W'($signed({1'b0, gain_rev_ff}));
   assign turn_l_in = PROD_W'(right_in) * PROD_W'($signed({1'b0, gain_turn_ff}));
   assign turn_r_in = PROD_W'(left_in)  * PROD_W'($signed({1'b0, gain_turn_ff}));

   always_comb begin
      unique case (case_sel)
         CASE_FORWARD: base_in = prod_fwd;
         CASE_REVERSE: base_in = prod_bwd;
         default:      base_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff   <= '0;
         bwd_ff   <= '0;
         left_ff  <= '0;
         right_ff <= '0;
      end else if (cmd_pop) begin
         fwd_ff   <= fwd_in;
         bwd_ff   <= bwd_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= cmd_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_case_ff <= case_sel;
         base_ff    <= base_in;
         turn_l_ff  <= turn_l_in;
         turn_r_ff  <= turn_r_in;
      end
   end

   // Stage two: sum, then split into magnitude and final sign
   assign sum_l = SUM_W'(base_ff) + SUM_W'(turn_l_ff);
   assign sum_r = SUM_W'(base_ff) + SUM_W'(turn_r_ff);
   assign abs_l = sum_l[SUM_W-1] ? SUM_W'(-sum_l) : SUM_W'(sum_l);
   assign abs_r = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_case_ff <= s1_case_ff;
         mag_l_ff   <= abs_l[MAG_W-1:0];
         mag_r_ff   <= abs_r[MAG_W-1:0];
         neg_l_ff   <= sum_l[SUM_W-1] ^ (s1_case_ff == CASE_REVERSE);
         neg_r_ff   <= sum_r[SUM_W-1] ^ (s1_case_ff == CASE_REVERSE);
      end
   end

   // Stage three: divide by ten through the reciprocal, saturate, apply sign
   assign recip_l = {{RECIP_W{1'b0}}, mag_l_ff} * {{MAG_W{1'b0}}, RECIP_TEN};
   assign recip_r = {{RECIP_W{1'b0}}, mag_r_ff} * {{MAG_W{1'b0}}, RECIP_TEN};
   assign quot_l  = recip_l[RECIP_SHIFT +: VALUE_W];
   assign quot_r  = recip_r[RECIP_SHIFT +: VALUE_W];
   assign sat_l   = (quot_l > VALUE_W'(FULL_SCALE)) ? VALUE_W'(FULL_SCALE) : quot_l;
   assign sat_r   = (quot_r > VALUE_W'(FULL_SCALE)) ? VALUE_W'(FULL_SCALE) : quot_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_case_ff  <= s2_case_ff;
         out_left_ff  <= neg_l_ff ? -$signed(sat_l) : $signed(sat_l);
         out_right_ff <= neg_r_ff ? -$signed(sat_r) : $signed(sat_r);
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.left_drive  = out_left_ff;
   assign rsp.right_drive = out_right_ff;
   assign rsp.drive_case  = out_case_ff;

   `DCPM_ASSERT_NEXT(a_pop_enters, cmd_pop, s1_valid_ff, "popped command missing in stage one")
   `DCPM_ASSERT_IMPLIES(a_fwd_base, s1_valid_ff && (s1_case_ff == CASE_FORWARD), base_ff >= 0, "forward mix with negative forward term")
   `DCPM_ASSERT_IMPLIES(a_drive_range, rsp.valid, (rsp.left_drive <= 15'sd10000) && (rsp.left_drive >= -15'sd10000), "left drive outside full scale")

endmodule

// ----- rtl/drive_command_parser_mixer.sv -----
// Drive command parser and mixer: takes one serial byte per cycle, no stall
// except while a finished command waits on a full two-entry queue.
// A result follows the last payload byte through the queue and the mix; one result per
// 12-byte frame at most, set by frame length; the mix takes one a cycle unless stalled.
// Reset is synchronous: frame state and speeds clear, gains load 6, 5 and 4 tenths.
module drive_command_parser_mixer import dcpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dcpm_req_if.sink    req_chan,
   dcpm_rsp_if.source  rsp_chan,
   dcpm_csr_if.sink    csr_chan
);

   cmd_type push_data, pop_data;
   logic    push, full, pop, empty;

   // Front end: frame and parse
   dcpm_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .cmd_data (push_data),
      .cmd_push (push),
      .cmd_full (full)
   );

   // Decouple front and back
   dcpm_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // Back end: mix and deliver
   dcpm_mixer u_mixer (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_chan),
      .rsp       (rsp_chan),
      .cmd_data  (pop_data),
      .cmd_empty (empty),
      .cmd_pop   (pop)
   );

endmodule

// ----- bench/drive_command_parser_mixer_tb.sv -----
// Self-checking bench for drive_command_parser_mixer: directed frames, then random
// command frames over several gain settings, each drive word checked against a predictor.
// Depends on dcpm_pkg, the dcpm channel interfaces and the block itself.
module drive_command_parser_mixer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dcpm_pkg::*;

   localparam int SCALE       = FULL_SCALE;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 5;
   localparam int PHASE_BYTES = 216;
   localparam int DIR_ROWS    = 14;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = '1;  // past the end of the register list
   localparam logic [7:0] CHAR_E = 8'h65;

   typedef enum logic [1:0] {PH_LEAD, PH_INT, PH_FRAC, PH_DONE} field_phase_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] left;
      logic signed [VALUE_W-1:0] right;
      drive_case_type            dcase;
   } drive_word_type;

   typedef struct packed {
      logic           typed;
      drive_word_type want;
   } row_check_type;

   logic clock;
   logic reset;

   dcpm_req_if req_chan ();
   dcpm_rsp_if rsp_chan ();
   dcpm_csr_if csr_chan ();

   drive_command_parser_mixer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Directed frames; a drive word is typed in only where it is plain from the frame
   string dir_text [DIR_ROWS] = '{
      "Zq 3.-!",                          // noise while idle, ignored
      "h1.000 0.500",                     // one point zero, turn only after reset
      "v-0    -0.00",                     // negative zero selects neither mix
      "v 0.5xh-0.25",                     // stop on junk, header byte as data
      "v-0   \011+9999",                  // saturate to one, reverse mix
      "h\011\012.5 x\013\014\015-3",      // every blank skipped before the number
      "h- 5 v.-    ",                     // blank after the sign stops the parse
      "v0.1e9 0x1F ",                     // exponent and hex forms not parsed
      "hinf  .0.1.5",                     // inf and a second point
      "h.0001 -.999",                     // smallest step, negative fraction
      "vhvhvhvhvhvh",                     // headers throughout the payload
      "v-1.50 -9.99",                     // both speeds negative
      "h99999 99999",                     // digits past saturation
      "v+9999 +1.0 "                      // full forward plus full turn
   };
   row_check_type dir_check [DIR_ROWS] = '{
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b1, '{15'sd2000, 15'sd4000, CASE_TURN}},
      '{1'b1, '{15'sd2000, 15'sd4000, CASE_TURN}},
      '{1'b1, '{15'sd5000, 15'sd7000, CASE_FORWARD}},
      '{1'b1, '{-15'sd7000, -15'sd9000, CASE_REVERSE}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}},
      '{1'b0, '{15'sd0, 15'sd0, CASE_TURN}}
   };

   // Predictor state
   logic [3:0]                gain_fwd, gain_rev, gain_turn;
   logic [COUNT_W-1:0]        frame_pos;
   logic                      cmd_vertical;
   field_phase_type           fld_phase;
   logic                      fld_neg;
   logic [2:0]                fld_frac_n;
   logic [ACCUM_W-1:0]        fld_mag;
   logic signed [VALUE_W-1:0] first_val, turn_left, turn_right, speed_fwd, speed_back;

   drive_word_type pending_drives [$];
   drive_word_type last_drive;
   int             fail_count = 0;
   int             source_gap_pct = 30;
   int             sink_stall_pct = 30;
   bit             rsp_hold_req = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Limit on the whole run
   initial begin
      #400_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int clamp_drive(input int v);
      if (v > SCALE) return SCALE;
      if (v < -SCALE) return -SCALE;
      return v;
   endfunction

   function automatic logic signed [VALUE_W-1:0] field_value_now();
      int m;
      m = fld_mag;
      return VALUE_W'(fld_neg ? -m : m);
   endfunction

   function automatic int drive_mismatches(input drive_word_type want,
                                           input drive_word_type got);
      int n;
      n = 0;
      if (got.left !== want.left) begin
         $error("left_drive: expected %0d, actual %0d", want.left, got.left);
         n++;
      end
      if (got.right !== want.right) begin
         $error("right_drive: expected %0d, actual %0d", want.right, got.right);
         n++;
      end
      if (got.dcase !== want.dcase) begin
         $error("drive_case: expected %0d, actual %0d", want.dcase, got.dcase);
         n++;
      end
      return n;
   endfunction

   task automatic clear_field();
      fld_phase  = PH_LEAD;
      fld_neg    = 1'b0;
      fld_frac_n = '0;
      fld_mag    = '0;
   endtask

   task automatic reset_model();
      gain_fwd     = FORWARD_GAIN_RESET;
      gain_rev     = REVERSE_GAIN_RESET;
      gain_turn    = TURN_GAIN_RESET;
      frame_pos    = '0;
      cmd_vertical = 1'b0;
      clear_field();
      first_val    = '0;
      turn_left    = '0;
      turn_right   = '0;
      speed_fwd    = '0;
      speed_back   = '0;
   endtask

   // Advance the number parse by one character
   task automatic feed_char(input logic [7:0] c);
      bit is_digit;
      int d, v, w;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = int'(c) - int'(CHAR_ZERO);
      if (fld_phase == PH_DONE) return;
      if (fld_phase == PH_LEAD) begin
         if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
         if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            fld_neg   = (c == CHAR_MINUS);
            fld_phase = PH_INT;
            return;
         end
         fld_phase = PH_INT;
      end
      if (fld_phase == PH_INT) begin
         if (is_digit) begin
            v = fld_mag * 10 + d * SCALE;
            fld_mag = ACCUM_W'((v > SCALE) ? SCALE : v);
         end else if (c == CHAR_POINT) begin
            fld_phase = PH_FRAC;
         end else begin
            fld_phase = PH_DONE;
         end
         return;
      end
      // fraction: digits past the fourth are eaten without effect
      if (is_digit) begin
         if (fld_frac_n < 4) begin
            w = 1000;
            repeat (fld_frac_n) w = w / 10;
            v = fld_mag + d * w;
            fld_mag = ACCUM_W'((v > SCALE) ? SCALE : v);
            fld_frac_n++;
         end
      end else begin
         fld_phase = PH_DONE;
      end
   endtask

   // Take one accepted byte; queue a drive word at the end of a frame
   task automatic take_byte(input logic [7:0] c);
      int p, f, b, l, r, gf, gr, gt, lv, rv;
      logic signed [VALUE_W-1:0] second;
      drive_word_type w;
      if (frame_pos == 0) begin
         if (c == CHAR_H || c == CHAR_V) begin
            cmd_vertical = (c == CHAR_V);
            frame_pos    = COUNT_W'(1);
            clear_field();
         end
         return;
      end
      p = frame_pos - 1;
      if (p == SECOND_FIELD_START) begin
         first_val = field_value_now();
         clear_field();
      end
      if (p < SECOND_FIELD_START) begin
         if (p < FIELD_CHARS) feed_char(c);
      end else if (p - SECOND_FIELD_START < FIELD_CHARS) begin
         feed_char(c);
      end
      if (p + 1 < PAYLOAD_LEN) begin
         frame_pos++;
         return;
      end

      // last payload byte: store the speeds, then mix
      frame_pos = '0;
      second = field_value_now();
      clear_field();
      if (cmd_vertical) begin
         speed_fwd  = first_val;
         speed_back = second;
      end else begin
         turn_left  = first_val;
         turn_right = second;
      end
      f  = speed_fwd;
      b  = speed_back;
      l  = turn_left;
      r  = turn_right;
      gf = gain_fwd;
      gr = gain_rev;
      gt = gain_turn;
      if (f > 0) begin
         lv = (f * gf + r * gt) / 10;
         rv = (f * gf + l * gt) / 10;
         w.dcase = CASE_FORWARD;
      end else if (b > 0) begin
         lv = -((b * gr + r * gt) / 10);
         rv = -((b * gr + l * gt) / 10);
         w.dcase = CASE_REVERSE;
      end else begin
         lv = (r * gt) / 10;
         rv = (l * gt) / 10;
         w.dcase = CASE_TURN;
      end
      w.left  = VALUE_W'(clamp_drive(lv));
      w.right = VALUE_W'(clamp_drive(rv));
      pending_drives.push_back(w);
   endtask

   // Track accepted words on every channel and check drive words in order
   always @(posedge clock) begin : track_words
      drive_word_type want, got;
      if (reset) begin
         reset_model();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               REG_FORWARD_GAIN: gain_fwd  = csr_chan.data;
               REG_REVERSE_GAIN: gain_rev  = csr_chan.data;
               REG_TURN_GAIN:    gain_turn = csr_chan.data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) take_byte(req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.left   = rsp_chan.left_drive;
            got.right  = rsp_chan.right_drive;
            got.dcase  = drive_case_type'(rsp_chan.drive_case);
            last_drive = got;
            if (pending_drives.size() == 0) begin
               $error("drive word with none expected: left %0d right %0d case %0d",
                      got.left, got.right, got.dcase);
               fail_count++;
            end else begin
               want = pending_drives.pop_front();
               fail_count += drive_mismatches(want, got);
            end
         end
      end
   end

   // Result sink: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
         end
      end
   end

   // Offer one byte, with random gaps ahead of it, and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < source_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and wait until every expected drive word has arrived
   task automatic settle_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] fwd, rev, turn, input bit poke_unused);
      write_reg(REG_FORWARD_GAIN, fwd);
      if (poke_unused) write_reg(REG_UNUSED, GAIN_W'($urandom));
      write_reg(REG_REVERSE_GAIN, rev);
      write_reg(REG_TURN_GAIN, turn);
      csr_chan.valid <= 1'b0;
   endtask

   // Send n bytes of a number field: blanks, sign, digits, point, then filler
   task automatic send_number(input int n);
      logic [7:0] s [$];
      int k;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            k = $urandom_range(0, 6);
            s.push_back((k > 4) ? CHAR_SPACE : 8'(CHAR_TAB + k));
         end
      end
      case ($urandom_range(0, 3))
         0:       s.push_back(CHAR_MINUS);
         1:       s.push_back(CHAR_PLUS);
         default: ;
      endcase
      k = $urandom_range(0, 2);
      if (k > 0)
         s.push_back(($urandom_range(0, 9) < 6) ?
                     CHAR_ZERO : 8'(CHAR_ZERO + $urandom_range(0, 9)));
      if (k > 1) s.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 3) != 0) begin
         s.push_back(CHAR_POINT);
         repeat ($urandom_range(0, 4)) s.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      while (s.size() < n) begin
         case ($urandom_range(0, 4))
            0:       s.push_back(CHAR_SPACE);
            1:       s.push_back(CHAR_POINT);
            2:       s.push_back(CHAR_E);
            3:       s.push_back(CHAR_MINUS);
            default: s.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      for (int i = 0; i < n; i++) send_byte(s[i]);
   endtask

   // One burst: mostly a well-formed frame, sometimes noise or a junk payload
   task automatic send_burst(inout int frame_bytes);
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_byte($urandom_range(0, 1) ? CHAR_H : CHAR_V);
         if (kind == 1) begin
            repeat (PAYLOAD_LEN) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_number(SECOND_FIELD_START);
            send_number(PAYLOAD_LEN - SECOND_FIELD_START);
         end
         frame_bytes += PAYLOAD_LEN + 1;
      end
   endtask

   // Main sequence
   initial begin
      int frame_bytes;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= REG_FORWARD_GAIN;
      csr_chan.data    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames, one at a time, under the reset gains
      for (int i = 0; i < DIR_ROWS; i++) begin
         for (int j = 0; j < dir_text[i].len(); j++) send_byte(dir_text[i][j]);
         settle_results();
         if (dir_check[i].typed) fail_count += drive_mismatches(dir_check[i].want, last_drive);
      end

      // random frames over several gain settings
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            // let the mix pipeline empty before touching the gains
            repeat (8) @(posedge clock);
            case (ph)
               1:       set_gains(4'd10, 4'd10, 4'd10, 1'b0);
               2:       set_gains(4'd0, 4'd0, 4'd0, 1'b0);
               3:       set_gains(4'd15, 4'd15, 4'd15, 1'b1);
               default: set_gains(GAIN_W'($urandom_range(0, 15)),
                                  GAIN_W'($urandom_range(0, 15)),
                                  GAIN_W'($urandom_range(0, 15)), 1'b1);
            endcase
         end
         // back up the block with a long sink hold-off, then run without any idling
         if (ph == 1) rsp_hold_req = 1'b1;
         source_gap_pct = (ph == 2) ? 0 : 30;
         sink_stall_pct = (ph == 2) ? 0 : 30;
         frame_bytes = 0;
         while (frame_bytes < PHASE_BYTES) send_burst(frame_bytes);
         settle_results();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
